// File: sv/shtlp_pkg.sv
// Shared types and constants for the linear-probe symbol hash table.
// No dependencies; imported by every other file of the block.
package shtlp_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int SLOT_W        = $clog2(TABLE_SIZE);
    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int KEY_BYTES     = KEY_W / 8;
    localparam int LEN_W         = 4;

    // Operation code carried by a request transaction
    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    // Result status carried by a response transaction
    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Access to the slot store for one cycle
    typedef struct packed
    {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [LEN_W-1:0]  wr_len;
    } mem_req_t;

    // Registered read data of the slot store; len of zero means empty
    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } mem_rsp_t;

endpackage

// File: sv/shtlp_req_if.sv
// Request channel of the symbol hash table: valid/ready plus operation and key.
// Depends on shtlp_pkg for field widths.
interface shtlp_req_if import shtlp_pkg::*;;
    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_len;

    modport source (output valid, output func, output key_bytes, output key_len,
                    input ready);
    modport sink   (input valid, input func, input key_bytes, input key_len,
                    output ready);
endinterface

// File: sv/shtlp_rsp_if.sv
// Response channel of the symbol hash table: valid/ready plus slot and status.
// Depends on shtlp_pkg for field widths.
interface shtlp_rsp_if import shtlp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

// File: sv/shtlp_hash.sv
// Key conditioning: clamps the length, masks unused bytes, forms the home slot.
// Depends on shtlp_pkg.
module shtlp_hash import shtlp_pkg::*;
(
    input  logic [KEY_W-1:0]  key_bytes,
    input  logic [LEN_W-1:0]  key_len,
    output logic [KEY_W-1:0]  key,
    output logic [LEN_W-1:0]  len,
    output logic [SLOT_W-1:0] home
);

    // Clamp the length into 1..MAX_KEY_BYTES
    always_comb
    begin
        if (key_len == '0)
            len = LEN_W'(1);
        else if (key_len > LEN_W'(MAX_KEY_BYTES))
            len = LEN_W'(MAX_KEY_BYTES);
        else
            len = key_len;
    end

    // Drop bytes beyond the key length
    always_comb
    begin
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (LEN_W'(i) < len)
                key[i*8 +: 8] = key_bytes[i*8 +: 8];
            else
                key[i*8 +: 8] = 8'h00;
        end
    end

    // Weighted byte sum, byte i weighted by i+1, kept mod table size
    always_comb
    begin
        logic [SLOT_W-1:0] acc;
        logic [15:0]       prod;
        acc = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            prod = 16'(key[i*8 +: 8]) * 16'(i + 1);
            acc  = acc + prod[SLOT_W-1:0];
        end
        home = acc;
    end

endmodule

// File: sv/shtlp_store.sv
// Slot store: key memory and length memory, one read and one write port each,
// read data registered; per-slot occupancy flops make empty slots read length 0.
// Depends on shtlp_pkg.
module shtlp_store import shtlp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
    logic [LEN_W-1:0]      len_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] occ_reg;
    logic                  rd_occ_reg;
    logic [KEY_W-1:0]      rd_key_reg;
    logic [LEN_W-1:0]      rd_len_reg;

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
            len_mem[req.wr_addr] <= req.wr_len;
        end
        if (req.rd_en)
        begin
            rd_key_reg <= key_mem[req.rd_addr];
            rd_len_reg <= len_mem[req.rd_addr];
        end
    end

    // Track occupied slots; reset empties the whole table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                occ_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_occ_reg <= occ_reg[req.rd_addr];
        end
    end

    assign rsp.key = rd_key_reg;
    assign rsp.len = rd_occ_reg ? rd_len_reg : '0;

`ifndef SYNTHESIS
    // A write and a read never target the same slot in one cycle
    a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
        else $error("store read and write collide on one slot");

    // An empty slot always reads length zero
    a_empty_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_occ_reg |-> (rsp.len == '0))
        else $error("empty slot read non-zero length");

    // Only non-zero lengths are ever stored
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (req.wr_len != '0))
        else $error("store written with zero length");
`endif

endmodule

// File: sv/symbol_hash_table_linear_probe.sv
// Top level of the linear-probe symbol hash table: probe sequencer and
// response register. Depends on shtlp_pkg, shtlp_req_if, shtlp_rsp_if,
// shtlp_hash and shtlp_store.
//
//   channel | dir | fields                         | accepted when
//   req     | in  | func, key_bytes, key_len       | req.valid && req.ready
//   rsp     | out | slot, status                   | rsp.valid && rsp.ready
//
// An item is accepted in S_IDLE, hashed in S_HASH, which issues the first
// read, then probed one slot per cycle (up to 256), set by the single read
// port of the slot store; the result enters the response register once free.
// Reset clears all slot occupancy flops at once; no clearing pass is needed.
// A new request is taken once the previous result sits in the response
// register; a stalled response holds the sequencer only when a second
// result is ready behind it.
module symbol_hash_table_linear_probe import shtlp_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    shtlp_req_if.sink    req,
    shtlp_rsp_if.source  rsp
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_HOLD
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    status_t           res_status_reg, res_status_next;
    logic              out_vld_reg, out_vld_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    status_t           out_status_reg, out_status_next;

    logic [KEY_W-1:0]  h_key;
    logic [LEN_W-1:0]  h_len;
    logic [SLOT_W-1:0] h_home;
    mem_req_t          mem_req;
    mem_rsp_t          mem_rsp;

    logic              out_free;
    logic              slot_empty;
    logic              slot_match;
    logic              last_probe;
    logic              done;
    logic [SLOT_W-1:0] done_slot;
    status_t           done_status;

    shtlp_hash u_hash
    (
        .key_bytes (key_reg),
        .key_len   (len_reg),
        .key       (h_key),
        .len       (h_len),
        .home      (h_home)
    );

    shtlp_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    assign out_free   = !out_vld_reg || rsp.ready;
    assign slot_empty = (mem_rsp.len == '0);
    assign slot_match = (mem_rsp.len == len_reg) && (mem_rsp.key == key_reg);
    assign last_probe = (cnt_reg == SLOT_W'(TABLE_SIZE - 1));

    // Decide the outcome of the slot read this cycle
    always_comb
    begin
        done        = 1'b0;
        done_slot   = '0;
        done_status = ST_MISSING;
        if (func_reg == FUNC_INSERT)
        begin
            if (slot_empty)
            begin
                done        = 1'b1;
                done_slot   = pos_reg;
                done_status = ST_INSERTED;
            end
            else if (last_probe)
            begin
                done        = 1'b1;
                done_status = ST_FULL;
            end
        end
        else
        begin
            if (slot_empty)
            begin
                done = 1'b1;
            end
            else if (slot_match)
            begin
                done        = 1'b1;
                done_slot   = pos_reg;
                done_status = ST_FOUND;
            end
            else if (last_probe)
            begin
                done = 1'b1;
            end
        end
    end

    // Sequence accept, hash, probe and result hand-off
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;

        mem_req         = '0;
        mem_req.rd_addr = pos_reg + SLOT_W'(1);
        mem_req.wr_addr = pos_reg;
        mem_req.wr_key  = key_reg;
        mem_req.wr_len  = len_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = func_t'(req.func);
                    key_next   = req.key_bytes;
                    len_next   = req.key_len;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                key_next        = h_key;
                len_next        = h_len;
                pos_next        = h_home;
                cnt_next        = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = h_home;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                if (done)
                begin
                    mem_req.wr_en   = (done_status == ST_INSERTED);
                    res_slot_next   = done_slot;
                    res_status_next = done_status;
                    if (out_free)
                    begin
                        out_vld_next    = 1'b1;
                        out_slot_next   = done_slot;
                        out_status_next = done_status;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
                else
                begin
                    // Advance to the next slot, wrapping round the table
                    mem_req.rd_en = 1'b1;
                    pos_next      = pos_reg + SLOT_W'(1);
                    cnt_next      = cnt_reg + SLOT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_vld_reg    <= 1'b0;
            out_slot_reg   <= '0;
            out_status_reg <= ST_INSERTED;
        end
        else
        begin
            state_reg      <= state_next;
            out_vld_reg    <= out_vld_next;
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_vld_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.status = out_status_reg;

`ifndef SYNTHESIS
    // An accepted request moves straight to hashing
    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_HASH))
        else $error("accepted request did not start hashing");

    // The store is written only by an insert that found an empty slot
    a_write_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == S_CHECK && func_reg == FUNC_INSERT && slot_empty))
        else $error("store written outside an insert hit on an empty slot");

    // Misses and a full table report slot zero
    a_none_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_MISSING || rsp.status == ST_FULL))
            |-> (rsp.slot == '0))
        else $error("miss or full result with non-zero slot");

    // A stalled response is not overwritten by the next result
    a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && out_vld_reg && !rsp.ready) |=> (state_reg == S_HOLD))
        else $error("pending result left hold while response stalled");
`endif

endmodule

// File: tb/symbol_hash_table_linear_probe_tb.sv
// Self-checking testbench for symbol_hash_table_linear_probe: drives insert and search
// requests, predicts each slot/status result with a behavioral table model.
// Depends on shtlp_pkg, shtlp_req_if, shtlp_rsp_if and the block's RTL.
`timescale 1ns / 100ps

module symbol_hash_table_linear_probe_tb;
    import shtlp_pkg::*;

    // Predicted outcome of one request
    typedef struct
    {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } lookup_result_t;

    // Key as it sits in the table after length clamping and masking
    typedef struct
    {
        logic [KEY_W-1:0] key;
        int               len;
    } symbol_entry_t;

    // Table shadow plus the queue of results still owed by the block
    class symtab_scoreboard;
        logic [KEY_W-1:0] slot_key [TABLE_SIZE];
        logic [LEN_W-1:0] slot_len [TABLE_SIZE];
        lookup_result_t   pending_results [$];
        int               mismatches = 0;
        int               results_seen = 0;
        int               inserts_sent = 0;
        int               searches_sent = 0;
        int               status_count [4];

        function new();
            foreach (slot_len[i])
            begin
                slot_len[i] = '0;
                slot_key[i] = '0;
            end
            foreach (status_count[i])
                status_count[i] = 0;
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        // Hash the key, walk the probe sequence and update the shadow table
        function lookup_result_t predict(func_t f, logic [KEY_W-1:0] raw_key,
                                         logic [LEN_W-1:0] raw_len);
            lookup_result_t    r;
            int                n;
            logic [KEY_W-1:0]  k;
            logic [7:0]        sum;
            logic [SLOT_W-1:0] pos;
            n = (raw_len == 0) ? 1 : (raw_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(raw_len);
            k = raw_key;
            for (int i = n; i < KEY_BYTES; i++)
                k[8*i +: 8] = 8'h00;
            sum = '0;
            for (int i = 0; i < n; i++)
                sum = sum + 8'(k[8*i +: 8] * (i + 1));
            pos = SLOT_W'(sum % TABLE_SIZE);
            r.slot = '0;
            if (f == FUNC_INSERT)
            begin
                r.status = ST_FULL;
                for (int v = 0; v < TABLE_SIZE; v++)
                begin
                    if (slot_len[pos] == 0)
                    begin
                        slot_key[pos] = k;
                        slot_len[pos] = LEN_W'(n);
                        r.slot        = pos;
                        r.status      = ST_INSERTED;
                        break;
                    end
                    pos = SLOT_W'((pos + 1) % TABLE_SIZE);
                end
            end
            else
            begin
                r.status = ST_MISSING;
                for (int v = 0; v < TABLE_SIZE; v++)
                begin
                    if (slot_len[pos] == 0)
                        break;
                    if (slot_len[pos] == LEN_W'(n) && slot_key[pos] == k)
                    begin
                        r.slot   = pos;
                        r.status = ST_FOUND;
                        break;
                    end
                    pos = SLOT_W'((pos + 1) % TABLE_SIZE);
                end
            end
            return r;
        endfunction

        function void note_request(func_t f, logic [KEY_W-1:0] raw_key,
                                   logic [LEN_W-1:0] raw_len);
            lookup_result_t r;
            if (f == FUNC_INSERT)
                inserts_sent++;
            else
                searches_sent++;
            r = predict(f, raw_key, raw_len);
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic [1:0] status);
            lookup_result_t want;
            results_seen++;
            status_count[status]++;
            if (pending_results.size() == 0)
            begin
                flag("unexpected transaction, slot", -1, slot);
                return;
            end
            want = pending_results.pop_front();
            if (slot !== want.slot)
                flag($sformatf("slot of result %0d", results_seen), want.slot, slot);
            if (status !== want.status)
                flag($sformatf("status of result %0d", results_seen), want.status, status);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    shtlp_req_if req_ch ();
    shtlp_rsp_if rsp_ch ();

    symbol_hash_table_linear_probe i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    symtab_scoreboard sb = new();
    symbol_entry_t    inserted_symbols [$];
    int               send_idle_pct = 35;
    int               recv_idle_pct = 56;
    int               hold_left = 0;
    bit               hold_done = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Global timeout
    initial
    begin
        #40_000_000;
        $display("symbol_hash_table_linear_probe_tb NOT OK");
        $finish;
    end

    // Offer one request and hold it until the block takes the transaction
    task automatic send_request(input func_t f, input logic [KEY_W-1:0] k,
                                input logic [LEN_W-1:0] n);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= f;
        req_ch.key_bytes <= k;
        req_ch.key_len   <= n;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(f, k, n);
    endtask

    // Drop valid and wait until every owed result has arrived
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Build a key: clustered short names, identifiers, or raw 64-bit data
    task automatic make_key(output logic [KEY_W-1:0] k, output int len);
        int mode;
        mode = $urandom_range(9);
        k    = '0;
        if (mode < 5)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                k[8*i +: 8] = 8'h61 + 8'($urandom_range(3));
        end
        else if (mode < 8)
        begin
            len = $urandom_range(1, MAX_KEY_BYTES);
            for (int i = 0; i < len; i++)
                k[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7e));
        end
        else
        begin
            len = $urandom_range(1, MAX_KEY_BYTES);
            k   = {$urandom, $urandom};
            for (int i = len; i < KEY_BYTES; i++)
                k[8*i +: 8] = 8'h00;
        end
    endtask

    task automatic send_random_item();
        func_t            f;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] junk;
        logic [LEN_W-1:0] n;
        int               len;
        int               idx;
        symbol_entry_t    entry;
        f = ($urandom_range(99) < 30) ? FUNC_INSERT : FUNC_SEARCH;
        if (f == FUNC_SEARCH && inserted_symbols.size() != 0 && $urandom_range(99) < 65)
        begin
            idx = $urandom_range(inserted_symbols.size() - 1);
            k   = inserted_symbols[idx].key;
            len = inserted_symbols[idx].len;
            // same bytes, one more length: must not match
            if ($urandom_range(9) == 0 && len < MAX_KEY_BYTES)
                len++;
        end
        else
            make_key(k, len);
        if (f == FUNC_INSERT)
        begin
            entry.key        = k;
            entry.len        = len;
            inserted_symbols = {inserted_symbols, entry};
        end
        // pad bytes beyond the length with garbage now and then
        if ($urandom_range(3) == 0)
        begin
            junk = {$urandom, $urandom};
            for (int i = len; i < KEY_BYTES; i++)
                k[8*i +: 8] = junk[8*i +: 8];
        end
        // encode the length, sometimes out of range
        if (len == 1 && $urandom_range(99) < 15)
            n = '0;
        else if (len == MAX_KEY_BYTES && $urandom_range(99) < 40)
            n = LEN_W'($urandom_range(MAX_KEY_BYTES + 1, 15));
        else
            n = LEN_W'(len);
        send_request(f, k, n);
    endtask

    // Response side: check accepted transactions, randomize ready, one long hold-off
    initial
    begin : rsp_side
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.slot, rsp_ch.status);
            if (!hold_done && sb.results_seen >= 450)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
                hold_left--;
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_INSERT;
        req_ch.key_bytes = '0;
        req_ch.key_len   = '0;
        rst_n            = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, length clamping, masking, duplicates,
        // length-only differences, collisions and wrap past the last slot
        send_request(FUNC_SEARCH, 64'h0, 4'd1);
        send_request(FUNC_INSERT, 64'h0, 4'd1);
        send_request(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_request(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_request(FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_request(FUNC_INSERT, 64'hDEAD_BEEF_0000_6261, 4'd2);
        send_request(FUNC_INSERT, 64'h0000_0000_0000_6261, 4'd2);
        send_request(FUNC_SEARCH, 64'h5555_0000_0000_6261, 4'd2);
        send_request(FUNC_SEARCH, 64'h0000_0000_0000_6261, 4'd3);
        send_request(FUNC_INSERT, 64'h0000_0000_0000_6261, 4'd3);
        send_request(FUNC_SEARCH, 64'h0000_0000_0000_6261, 4'd3);
        send_request(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12);
        send_request(FUNC_SEARCH, 64'hA5A5_A5A5_A5A5_A5FF, 4'd0);
        send_request(FUNC_SEARCH, 64'h0, 4'd1);
        send_request(FUNC_INSERT, 64'h03, 4'd1);
        send_request(FUNC_INSERT, 64'h0101, 4'd2);
        send_request(FUNC_SEARCH, 64'h0101, 4'd2);
        send_request(FUNC_INSERT, 64'hFF, 4'd1);
        send_request(FUNC_SEARCH, 64'h01FD, 4'd2);
        send_request(FUNC_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_request(FUNC_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd7);

        // Random: sender idles less than receiver
        repeat (350) send_random_item();
        drain_results();

        // Random: receiver idles less than sender
        send_idle_pct = 56;
        recv_idle_pct = 35;
        repeat (370) send_random_item();
        drain_results();

        // Random at full rate; the table fills up here
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (360) send_random_item();
        drain_results();
        repeat (300) @(posedge clk);

        if (sb.pending_results.size() != 0)
            sb.flag("leftover expectations", 0, sb.pending_results.size());
        $display("Covered %0d inserts and %0d searches with idle/stall mixes and a long hold-off",
                 sb.inserts_sent, sb.searches_sent);
        $display("Results: %0d inserted, %0d found, %0d not found, %0d table full; %0d mismatches",
                 sb.status_count[ST_INSERTED], sb.status_count[ST_FOUND],
                 sb.status_count[ST_MISSING], sb.status_count[ST_FULL], sb.mismatches);
        if (sb.mismatches == 0)
            $display("symbol_hash_table_linear_probe_tb OK");
        else
            $display("symbol_hash_table_linear_probe_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
sv/shtlp_pkg.sv
sv/shtlp_req_if.sv
sv/shtlp_rsp_if.sv
sv/shtlp_hash.sv
sv/shtlp_store.sv
sv/symbol_hash_table_linear_probe.sv
tb/symbol_hash_table_linear_probe_tb.sv
